[rtl/osf_pkg.sv]
package osf_pkg;

    localparam logic [1:0] MODE_TOTAL = 2'd0;
    localparam logic [1:0] MODE_TRIP  = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;

    localparam logic [19:0] TOTAL_MAX = 20'd999999;
    localparam logic [19:0] TRIP_MAX  = 20'd9999;
    localparam logic [19:0] FIXED_MAX = 20'd99999;
    localparam logic [3:0]  DIGIT_MAX = 4'd9;

    // floor(v / 1000) == (v * DIV1000_MUL) >> DIV1000_SHIFT for v < 2**20
    localparam int          DIV1000_SHIFT = 30;
    localparam logic [40:0] DIV1000_MUL   = 41'd1073742;

    localparam logic [6:0] SEG_A = 7'h01;
    localparam logic [6:0] SEG_B = 7'h02;
    localparam logic [6:0] SEG_C = 7'h04;
    localparam logic [6:0] SEG_D = 7'h08;
    localparam logic [6:0] SEG_E = 7'h10;
    localparam logic [6:0] SEG_F = 7'h20;
    localparam logic [6:0] SEG_G = 7'h40;
    localparam logic [6:0] SEG_BLANK = 7'h00;

    typedef struct packed {
        logic [1:0]  func;
        logic [19:0] value;
        logic [3:0]  frac_digit;
    } cmd_t;

    typedef struct packed {
        logic [6:0] seg_pos0;
        logic [6:0] seg_pos1;
        logic [6:0] seg_pos2;
        logic [6:0] seg_pos3;
        logic [6:0] seg_pos4;
        logic [6:0] seg_pos5;
        logic       point_on;
        logic       status;
    } disp_t;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] frac_digit;
        logic       bad;
    } ctl_t;

    typedef struct packed {
        logic [3:0] hi;
        logic [6:0] rem;
    } div100_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } div10_t;

    // x below 1000
    function automatic div100_t split100(input logic [9:0] x);
        logic [15:0] prod;
        logic [9:0]  rest;
        div100_t     res;
        prod     = {6'd0, x} * 16'd41;
        res.hi   = prod[15:12];
        rest     = x - {6'd0, res.hi} * 10'd100;
        res.rem  = rest[6:0];
        return res;
    endfunction

    // x below 100
    function automatic div10_t split10(input logic [6:0] x);
        logic [14:0] prod;
        logic [6:0]  rest;
        div10_t      res;
        prod     = {8'd0, x} * 15'd205;
        res.tens = prod[14:11];
        rest     = x - {3'd0, res.tens} * 7'd10;
        res.ones = rest[3:0];
        return res;
    endfunction

    function automatic logic [6:0] seg_encode(input logic [3:0] d);
        logic [6:0] seg;
        unique case (d)
            4'd0:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    seg = SEG_B | SEG_C;
            4'd2:    seg = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    seg = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5:    seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6:    seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7:    seg = SEG_A | SEG_B | SEG_C;
            4'd8:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

[rtl/odometer_seven_segment_formatter.sv]
// Throughput: one word per cycle unless a disp_stall holds the output; six
// register stages (range check, divide by 1000, remainder, divide by 100,
// divide by 10, blank and encode).
// A disp_stall freezes every stage at once while the output word is held.
// Reset (rst_n low, asynchronous) clears all stage valid bits; no word is
// lost or repeated across a stall.
module odometer_seven_segment_formatter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  osf_pkg::cmd_t         cmd,
    output logic                  disp_valid,
    input  logic                  disp_stall,
    output osf_pkg::disp_t        disp
);

    logic advance;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                s4_valid_reg, s5_valid_reg, disp_valid_reg;
    osf_pkg::ctl_t       s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;
    osf_pkg::ctl_t       s1_ctl_next;
    logic [19:0]         s1_val_reg, s1_val_next, s2_val_reg;
    logic [9:0]          s2_q_reg, s2_q_next, s3_q_reg, s3_r_reg, s3_r_next;
    osf_pkg::div100_t    s4_q_reg, s4_r_reg, s4_q_next, s4_r_next;
    logic [3:0]          s5_dig_reg [6];
    osf_pkg::div10_t     s5_qt_next, s5_rt_next;
    osf_pkg::disp_t      disp_reg, disp_next;

    logic [40:0]         s2_prod;
    logic [19:0]         s3_q1000;
    logic [4:0]          lead_zero;
    logic [5:0]          blank;
    logic [6:0]          seg [6];

    assign advance   = !(disp_valid_reg && disp_stall);
    assign cmd_stall = !advance;

    // stage 1: range check; saturate total and trip, flag bad fixed and undefined words
    always_comb
    begin
        s1_ctl_next.func       = cmd.func;
        s1_ctl_next.frac_digit = cmd.frac_digit;
        s1_ctl_next.bad        = 1'b0;
        s1_val_next            = cmd.value;
        case (cmd.func)
            osf_pkg::MODE_TOTAL:
            begin
                if (cmd.value > osf_pkg::TOTAL_MAX)
                begin
                    s1_val_next = osf_pkg::TOTAL_MAX;
                end
            end
            osf_pkg::MODE_TRIP:
            begin
                if (cmd.value > osf_pkg::TRIP_MAX)
                begin
                    s1_val_next = osf_pkg::TRIP_MAX;
                end
            end
            osf_pkg::MODE_FIXED:
            begin
                if (cmd.value > osf_pkg::FIXED_MAX || cmd.frac_digit > osf_pkg::DIGIT_MAX)
                begin
                    s1_ctl_next.bad = 1'b1;
                    s1_val_next     = '0;
                end
            end
            default:
            begin
                s1_ctl_next.bad = 1'b1;
                s1_val_next     = '0;
            end
        endcase
    end

    // stage 2: thousands
    assign s2_prod   = {21'd0, s1_val_reg} * osf_pkg::DIV1000_MUL;
    assign s2_q_next = s2_prod[osf_pkg::DIV1000_SHIFT +: 10];

    // stage 3: remainder below 1000
    assign s3_q1000  = {10'd0, s2_q_reg} * 20'd1000;
    assign s3_r_next = 10'(s2_val_reg - s3_q1000);

    // stage 4: hundreds
    assign s4_q_next = osf_pkg::split100(s3_q_reg);
    assign s4_r_next = osf_pkg::split100(s3_r_reg);

    // stage 5: tens and ones
    assign s5_qt_next = osf_pkg::split10(s4_q_reg.rem);
    assign s5_rt_next = osf_pkg::split10(s4_r_reg.rem);

    // stage 6: blank and encode
    always_comb
    begin
        lead_zero[0] = (s5_dig_reg[0] == 4'd0);
        for (int i = 1; i < 5; i++)
        begin
            lead_zero[i] = lead_zero[i-1] && (s5_dig_reg[i] == 4'd0);
        end
        blank = '0;
        case (s5_ctl_reg.func)
            osf_pkg::MODE_TOTAL: blank = {1'b0, lead_zero[4:0]};
            osf_pkg::MODE_TRIP:  blank = {2'b00, lead_zero[3:0]};
            default:             blank = '0;
        endcase
        for (int i = 0; i < 6; i++)
        begin
            seg[i] = blank[i] ? osf_pkg::SEG_BLANK : osf_pkg::seg_encode(s5_dig_reg[i]);
        end
        if (s5_ctl_reg.func == osf_pkg::MODE_FIXED)
        begin
            // show the five low digits, then the fraction digit
            for (int i = 0; i < 5; i++)
            begin
                seg[i] = osf_pkg::seg_encode(s5_dig_reg[i+1]);
            end
            seg[5] = osf_pkg::seg_encode(s5_ctl_reg.frac_digit);
        end
        disp_next.seg_pos0 = seg[0];
        disp_next.seg_pos1 = seg[1];
        disp_next.seg_pos2 = seg[2];
        disp_next.seg_pos3 = seg[3];
        disp_next.seg_pos4 = seg[4];
        disp_next.seg_pos5 = seg[5];
        disp_next.point_on = (s5_ctl_reg.func != osf_pkg::MODE_TOTAL);
        disp_next.status   = 1'b0;
        if (s5_ctl_reg.bad)
        begin
            disp_next        = '0;
            disp_next.status = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            disp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg   <= cmd_valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            s5_valid_reg   <= s4_valid_reg;
            disp_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg    <= s1_ctl_next;
            s1_val_reg    <= s1_val_next;
            s2_ctl_reg    <= s1_ctl_reg;
            s2_val_reg    <= s1_val_reg;
            s2_q_reg      <= s2_q_next;
            s3_ctl_reg    <= s2_ctl_reg;
            s3_q_reg      <= s2_q_reg;
            s3_r_reg      <= s3_r_next;
            s4_ctl_reg    <= s3_ctl_reg;
            s4_q_reg      <= s4_q_next;
            s4_r_reg      <= s4_r_next;
            s5_ctl_reg    <= s4_ctl_reg;
            s5_dig_reg[0] <= s4_q_reg.hi;
            s5_dig_reg[1] <= s5_qt_next.tens;
            s5_dig_reg[2] <= s5_qt_next.ones;
            s5_dig_reg[3] <= s4_r_reg.hi;
            s5_dig_reg[4] <= s5_rt_next.tens;
            s5_dig_reg[5] <= s5_rt_next.ones;
            disp_reg      <= disp_next;
        end
    end

    assign disp_valid = disp_valid_reg;
    assign disp       = disp_reg;

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_q_reg <= 10'd999)
        else $error("thousands quotient out of range");

    a_remainder_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_r_reg <= 10'd999)
        else $error("remainder out of range");

    a_bad_blank: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid_reg && disp_reg.status |->
            !disp_reg.point_on && disp_reg.seg_pos0 == osf_pkg::SEG_BLANK &&
            disp_reg.seg_pos5 == osf_pkg::SEG_BLANK)
        else $error("invalid word carries segments");

    a_last_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid_reg && !disp_reg.status |-> disp_reg.seg_pos5 != osf_pkg::SEG_BLANK)
        else $error("rightmost digit blanked");

    a_point_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid_reg && disp_reg.point_on |-> disp_reg.seg_pos4 != osf_pkg::SEG_BLANK)
        else $error("digit before point blanked");

endmodule

[tb/odometer_seven_segment_formatter_test.sv]
`timescale 1ns / 1ps

module odometer_seven_segment_formatter_test;

    localparam logic [1:0] MODE_UNDEF = 2'd3;
    localparam int RANDOM_WORDS = 650;
    localparam int IDLE_PCT = 28;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int BLANK_DIGIT = -1;

    typedef struct {
        osf_pkg::cmd_t word;
        bit            drain;
        bit            steady;
    } request_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    osf_pkg::cmd_t  cmd = '0;
    logic           disp_valid;
    logic           disp_stall = 1'b0;
    osf_pkg::disp_t disp;

    logic  quiet = 1'b0;

    request_t       request_q[$];
    osf_pkg::disp_t reading_q[$];

    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int invalid_count = 0;
    int mode_count[4];
    int idle_cycles = 0;

    odometer_seven_segment_formatter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall),
        .disp       (disp)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [6:0] digit_pattern(int d);
        case (d)
            0:       return osf_pkg::SEG_A | osf_pkg::SEG_B | osf_pkg::SEG_C | osf_pkg::SEG_D
                            | osf_pkg::SEG_E | osf_pkg::SEG_F;
            1:       return osf_pkg::SEG_B | osf_pkg::SEG_C;
            2:       return osf_pkg::SEG_A | osf_pkg::SEG_B | osf_pkg::SEG_D | osf_pkg::SEG_E
                            | osf_pkg::SEG_G;
            3:       return osf_pkg::SEG_A | osf_pkg::SEG_B | osf_pkg::SEG_C | osf_pkg::SEG_D
                            | osf_pkg::SEG_G;
            4:       return osf_pkg::SEG_B | osf_pkg::SEG_C | osf_pkg::SEG_F | osf_pkg::SEG_G;
            5:       return osf_pkg::SEG_A | osf_pkg::SEG_C | osf_pkg::SEG_D | osf_pkg::SEG_F
                            | osf_pkg::SEG_G;
            6:       return osf_pkg::SEG_A | osf_pkg::SEG_C | osf_pkg::SEG_D | osf_pkg::SEG_E
                            | osf_pkg::SEG_F | osf_pkg::SEG_G;
            7:       return osf_pkg::SEG_A | osf_pkg::SEG_B | osf_pkg::SEG_C;
            8:       return osf_pkg::SEG_A | osf_pkg::SEG_B | osf_pkg::SEG_C | osf_pkg::SEG_D
                            | osf_pkg::SEG_E | osf_pkg::SEG_F | osf_pkg::SEG_G;
            9:       return osf_pkg::SEG_A | osf_pkg::SEG_B | osf_pkg::SEG_C | osf_pkg::SEG_D
                            | osf_pkg::SEG_F | osf_pkg::SEG_G;
            default: return osf_pkg::SEG_BLANK;
        endcase
    endfunction

    function automatic osf_pkg::disp_t format_reading(osf_pkg::cmd_t c);
        osf_pkg::disp_t r;
        int    v;
        int    dd;
        int    scale;
        int    d;
        int    whole;
        int    dig[6];
        bit    lead;
        r  = '0;
        v  = int'(c.value);
        dd = int'(c.frac_digit);
        case (c.func)
            osf_pkg::MODE_TOTAL:
            begin
                if (v > int'(osf_pkg::TOTAL_MAX))
                    v = int'(osf_pkg::TOTAL_MAX);
                lead  = 1'b1;
                scale = 100000;
                for (int k = 0; k < 6; k++)
                begin
                    d = (v / scale) % 10;
                    if (d != 0 || k == 5)
                        lead = 1'b0;
                    dig[k] = lead ? BLANK_DIGIT : d;
                    scale  = scale / 10;
                end
                r.point_on = 1'b0;
            end
            osf_pkg::MODE_TRIP:
            begin
                if (v > int'(osf_pkg::TRIP_MAX))
                    v = int'(osf_pkg::TRIP_MAX);
                whole  = v / 10;
                dig[0] = BLANK_DIGIT;
                dig[1] = BLANK_DIGIT;
                dig[2] = (whole >= 100) ? whole / 100 : BLANK_DIGIT;
                dig[3] = (whole >= 10) ? (whole / 10) % 10 : BLANK_DIGIT;
                dig[4] = whole % 10;
                dig[5] = v % 10;
                r.point_on = 1'b1;
            end
            osf_pkg::MODE_FIXED:
            begin
                if (v > int'(osf_pkg::FIXED_MAX) || dd > int'(osf_pkg::DIGIT_MAX))
                begin
                    r.status = 1'b1;
                    return r;
                end
                dig[0] = (v / 10000) % 10;
                dig[1] = (v / 1000) % 10;
                dig[2] = (v / 100) % 10;
                dig[3] = (v / 10) % 10;
                dig[4] = v % 10;
                dig[5] = dd;
                r.point_on = 1'b1;
            end
            default:
            begin
                r.status = 1'b1;
                return r;
            end
        endcase
        r.seg_pos0 = digit_pattern(dig[0]);
        r.seg_pos1 = digit_pattern(dig[1]);
        r.seg_pos2 = digit_pattern(dig[2]);
        r.seg_pos3 = digit_pattern(dig[3]);
        r.seg_pos4 = digit_pattern(dig[4]);
        r.seg_pos5 = digit_pattern(dig[5]);
        r.status   = 1'b0;
        return r;
    endfunction

    task automatic push_request(logic [1:0] f, int v, int dd, bit drain, bit steady);
        request_t q;
        q.word.func       = f;
        q.word.value      = 20'(v);
        q.word.frac_digit = 4'(dd);
        q.drain           = drain;
        q.steady          = steady;
        request_q.push_back(q);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        bit             took;
        osf_pkg::disp_t want;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            quiet     <= 1'b0;
        end
        else
        begin
            took = cmd_valid && !cmd_stall;
            if (took)
            begin
                want = format_reading(cmd);
                reading_q.push_back(want);
                words_sent++;
                mode_count[cmd.func]++;
                if (want.status)
                    invalid_count++;
            end
            if (!cmd_valid || took)
            begin
                // hold a draining word until every reply is back
                if (request_q.size() > 0
                    && !(request_q[0].drain && reading_q.size() != 0)
                    && (request_q[0].steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= request_q[0].word;
                    quiet     <= request_q[0].steady;
                    request_q.pop_front();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        osf_pkg::disp_t want;
        if (!rst_n)
        begin
            disp_stall <= 1'b0;
        end
        else
        begin
            if (disp_valid && !disp_stall)
            begin
                if (reading_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: %h", disp);
                end
                else
                begin
                    want = reading_q.pop_front();
                    words_checked++;
                    if (disp.seg_pos0 !== want.seg_pos0 || disp.seg_pos1 !== want.seg_pos1
                        || disp.seg_pos2 !== want.seg_pos2 || disp.seg_pos3 !== want.seg_pos3
                        || disp.seg_pos4 !== want.seg_pos4 || disp.seg_pos5 !== want.seg_pos5
                        || disp.point_on !== want.point_on || disp.status !== want.status)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch on word %0d: exp seg %h %h %h %h %h %h dp %b st %b",
                                     words_checked,
                                     want.seg_pos0, want.seg_pos1, want.seg_pos2,
                                     want.seg_pos3, want.seg_pos4, want.seg_pos5,
                                     want.point_on, want.status);
                            $display("    got seg %h %h %h %h %h %h dp %b st %b",
                                     disp.seg_pos0, disp.seg_pos1, disp.seg_pos2,
                                     disp.seg_pos3, disp.seg_pos4, disp.seg_pos5,
                                     disp.point_on, disp.status);
                        end
                    end
                end
            end
            disp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (disp_valid && !disp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("odometer_seven_segment_formatter_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [1:0] f;
        int         lim;
        int         v;
        int         dd;
        int         pick;
        foreach (mode_count[m])
            mode_count[m] = 0;

        // directed corners
        push_request(osf_pkg::MODE_TOTAL, 0, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TOTAL, 5, 15, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TOTAL, 10, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TOTAL, 100000, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TOTAL, 123456, 3, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TOTAL, 999999, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TOTAL, 1000000, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TOTAL, 1048575, 15, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 0, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 9, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 10, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 99, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 100, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 1005, 9, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 9999, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 10000, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_TRIP, 1048575, 15, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_FIXED, 0, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_FIXED, 0, 9, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_FIXED, 12345, 7, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_FIXED, 99999, 9, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_FIXED, 100000, 0, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_FIXED, 12345, 10, 1'b0, 1'b0);
        push_request(osf_pkg::MODE_FIXED, 1048575, 15, 1'b0, 1'b0);
        push_request(MODE_UNDEF, 0, 0, 1'b0, 1'b0);
        push_request(MODE_UNDEF, 1048575, 15, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                f = osf_pkg::MODE_TOTAL;
            else if (pick < 60)
                f = osf_pkg::MODE_TRIP;
            else if (pick < 90)
                f = osf_pkg::MODE_FIXED;
            else
                f = MODE_UNDEF;
            case (f)
                osf_pkg::MODE_TOTAL: lim = int'(osf_pkg::TOTAL_MAX);
                osf_pkg::MODE_TRIP:  lim = int'(osf_pkg::TRIP_MAX);
                default:             lim = int'(osf_pkg::FIXED_MAX);
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 2)
                v = int'(20'($urandom()));
            else if (pick == 2)
                v = lim - 1 + $urandom_range(0, 2);
            else if (pick < 5)
                v = $urandom_range(0, 10 ** $urandom_range(1, 4));
            else
                v = $urandom_range(0, lim);
            if (f == osf_pkg::MODE_FIXED)
                dd = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9) : $urandom_range(10, 15);
            else
                dd = $urandom_range(0, 15);
            push_request(f, v, dd, (n == 0 || n == 300 || n == 520),
                         (n >= 120 && n < 280));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || cmd_valid)
            @(negedge clk);
        while (reading_q.size() != 0)
            @(negedge clk);
        repeat (12) @(posedge clk);

        $display("checked %0d of %0d words: total %0d, trip %0d, fixed %0d, undefined %0d",
                 words_checked, words_sent, mode_count[osf_pkg::MODE_TOTAL],
                 mode_count[osf_pkg::MODE_TRIP], mode_count[osf_pkg::MODE_FIXED],
                 mode_count[MODE_UNDEF]);
        $display("%0d invalid replies, %0d mismatches", invalid_count, errors);
        if (errors == 0 && reading_q.size() == 0)
            $display("odometer_seven_segment_formatter_test: PASS");
        else
            $display("odometer_seven_segment_formatter_test: FAIL");
        $finish;
    end

endmodule
